### hw/rtl/kvc_pkg.sv
`default_nettype none
package kvc_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int SCAN_W     = IDX_W + 1;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int STAMP_BITS = 32;
    localparam int CAP_W      = 7;

    localparam logic [3:0] FUNC_SET    = 4'd0;
    localparam logic [3:0] FUNC_SETTTL = 4'd1;
    localparam logic [3:0] FUNC_GET    = 4'd2;
    localparam logic [3:0] FUNC_DEL    = 4'd3;
    localparam logic [3:0] FUNC_EXISTS = 4'd4;
    localparam logic [3:0] FUNC_TTL    = 4'd5;
    localparam logic [3:0] FUNC_EXPIRE = 4'd6;
    localparam logic [3:0] FUNC_CLEAR  = 4'd7;
    localparam logic [3:0] FUNC_TICK   = 4'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_BADLIFE = 2'd2;

    localparam logic signed [32:0] TTL_ABSENT = -33'sd2;
    localparam logic signed [32:0] TTL_NONE   = -33'sd1;

    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0]  expiry;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_BITS-1:0] stamp;
    } meta_t;

    typedef struct packed {
        logic                  key_en;
        logic                  val_en;
        logic                  meta_en;
        logic [IDX_W-1:0]      addr;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        meta_t                 meta;
    } wr_t;

endpackage
`default_nettype wire

### hw/rtl/kvc_store.sv
`default_nettype none
module kvc_store (
    input  wire logic                            aclk,
    input  wire logic [kvc_pkg::IDX_W-1:0]       rd_addr,
    input  wire kvc_pkg::wr_t                    wr,
    output logic [kvc_pkg::KEY_BITS-1:0]         rd_key,
    output logic [kvc_pkg::VALUE_BITS-1:0]       rd_value,
    output kvc_pkg::meta_t                       rd_meta
);

    logic [kvc_pkg::KEY_BITS-1:0]   key_mem   [kvc_pkg::ENTRIES];
    logic [kvc_pkg::VALUE_BITS-1:0] value_mem [kvc_pkg::ENTRIES];
    kvc_pkg::meta_t                 meta_mem  [kvc_pkg::ENTRIES];

    logic [kvc_pkg::KEY_BITS-1:0]   rd_key_reg;
    logic [kvc_pkg::VALUE_BITS-1:0] rd_value_reg;
    kvc_pkg::meta_t                 rd_meta_reg;

    always_ff @(posedge aclk) begin
        if (wr.key_en) begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.val_en) begin
            value_mem[wr.addr] <= wr.value;
        end
        if (wr.meta_en) begin
            meta_mem[wr.addr] <= wr.meta;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
        rd_meta_reg  <= meta_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;
    assign rd_meta  = rd_meta_reg;

endmodule
`default_nettype wire

### hw/rtl/ttl_key_value_cache_lru_lfu_top.sv
`default_nettype none
// Key-value cache with 64 entries, LRU or LFU eviction and per-entry time to live.
// Requests are taken one at a time. Every lookup sweeps the entry memories through
// their single read port, one entry per cycle; a set that misses in a full cache
// adds one further sweep for each extra victim when the capacity was lowered below
// the live count. Clear takes one sweep; tick and rejected lifetimes take none. The
// next request is taken while a finished result still waits on the result channel.
module ttl_key_value_cache_lru_lfu_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [3:0]            s_func,
    input  wire logic [63:0]           s_key,
    input  wire logic [63:0]           s_value,
    input  wire logic [31:0]           s_lifetime_seconds,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic [63:0]                m_read_value,
    output logic signed [32:0]         m_ttl_remaining,
    output logic                       m_evicted,
    output logic [6:0]                 m_cleared_count
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_ACT      = 3'd3;
    localparam logic [2:0] S_EVICT    = 3'd4;
    localparam logic [2:0] S_INSERT   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam logic [1:0] M_FIND   = 2'd0;
    localparam logic [1:0] M_VICTIM = 2'd1;
    localparam logic [1:0] M_CLEAR  = 2'd2;

    localparam int N = kvc_pkg::ENTRIES;
    localparam int IW = kvc_pkg::IDX_W;
    localparam int SW = kvc_pkg::SCAN_W;
    localparam int CW = kvc_pkg::CAP_W;

    logic [2:0] state_reg;
    logic [1:0] mode_reg;

    logic                           policy_reg;
    logic [CW-1:0]                  cap_reg;
    logic [kvc_pkg::TIME_BITS-1:0]  now_reg;
    logic [kvc_pkg::STAMP_BITS-1:0] stamp_reg;
    logic [N-1:0]                   valid_reg;
    logic [N-1:0]                   hasexp_reg;

    logic [3:0]                     func_reg;
    logic [kvc_pkg::KEY_BITS-1:0]   key_reg;
    logic [kvc_pkg::VALUE_BITS-1:0] value_reg;
    logic [kvc_pkg::TIME_BITS-1:0]  life_reg;
    logic [kvc_pkg::TIME_BITS-1:0]  exp_new_reg;

    logic [SW-1:0] scan_addr_reg;
    logic          data_vld_reg;
    logic [IW-1:0] data_idx_reg;

    logic                           hit_reg;
    logic [IW-1:0]                  hit_idx_reg;
    kvc_pkg::meta_t                 hit_meta_reg;
    logic [kvc_pkg::VALUE_BITS-1:0] hit_val_reg;
    logic [CW-1:0]                  live_cnt_reg;
    logic                           free_found_reg;
    logic [IW-1:0]                  free_idx_reg;
    logic                           vic_found_reg;
    logic [IW-1:0]                  vic_idx_reg;
    logic [kvc_pkg::COUNT_BITS-1:0] vic_count_reg;
    logic [kvc_pkg::STAMP_BITS-1:0] vic_stamp_reg;

    logic [1:0]        res_status_reg;
    logic [63:0]       res_rv_reg;
    logic signed [32:0] res_ttl_reg;
    logic              res_ev_reg;
    logic [6:0]        res_cleared_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [63:0]       m_rv_reg;
    logic signed [32:0] m_ttl_reg;
    logic              m_ev_reg;
    logic [6:0]        m_cleared_reg;

    logic [kvc_pkg::KEY_BITS-1:0]   rd_key;
    logic [kvc_pkg::VALUE_BITS-1:0] rd_value;
    kvc_pkg::meta_t                 rd_meta;
    kvc_pkg::wr_t                   wr;

    logic                   cfg_wr;
    logic                   s_accept;
    logic [CW-1:0]          cap_eff;
    logic                   e_live;
    logic                   e_match;
    logic                   e_better;
    logic                   scan_last;
    logic [32:0]            exp_sum;
    logic                   is_touch;
    logic                   is_set;
    logic [kvc_pkg::COUNT_BITS-1:0] touch_count;

    kvc_store u_store (
        .aclk    (aclk),
        .rd_addr (scan_addr_reg[IW-1:0]),
        .wr      (wr),
        .rd_key  (rd_key),
        .rd_value(rd_value),
        .rd_meta (rd_meta)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == kvc_pkg::REG_CAPACITY) begin
            prdata[CW-1:0] = cap_reg;
        end else begin
            prdata[0] = policy_reg;
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (cap_reg > CW'(N)) begin
            cap_eff = CW'(N);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign exp_sum = {1'b0, now_reg} + {1'b0, life_reg};

    assign e_live  = valid_reg[data_idx_reg] &&
                     !(hasexp_reg[data_idx_reg] && (now_reg >= rd_meta.expiry));
    assign e_match = valid_reg[data_idx_reg] && (rd_key == key_reg);
    assign e_better = !vic_found_reg ||
        (policy_reg ? ((rd_meta.count < vic_count_reg) ||
                       ((rd_meta.count == vic_count_reg) && (rd_meta.stamp < vic_stamp_reg)))
                    : (rd_meta.stamp < vic_stamp_reg));
    assign scan_last = data_vld_reg && (data_idx_reg == IW'(N - 1));

    assign is_set   = (func_reg == kvc_pkg::FUNC_SET) || (func_reg == kvc_pkg::FUNC_SETTTL);
    assign is_touch = is_set || (func_reg == kvc_pkg::FUNC_GET) ||
                      (func_reg == kvc_pkg::FUNC_EXPIRE);
    assign touch_count = (hit_meta_reg.count == '1) ? hit_meta_reg.count
                       : hit_meta_reg.count + kvc_pkg::COUNT_BITS'(1);

    always_comb begin
        wr = '0;
        if (state_reg == S_ACT && hit_reg && is_touch) begin
            wr.addr         = hit_idx_reg;
            wr.val_en       = is_set;
            wr.value        = value_reg;
            wr.meta_en      = 1'b1;
            wr.meta.count   = touch_count;
            wr.meta.stamp   = stamp_reg;
            if (func_reg == kvc_pkg::FUNC_SET) begin
                wr.meta.expiry = '0;
            end else if (func_reg == kvc_pkg::FUNC_GET) begin
                wr.meta.expiry = hit_meta_reg.expiry;
            end else begin
                wr.meta.expiry = exp_new_reg;
            end
        end else if (state_reg == S_INSERT) begin
            wr.addr        = free_idx_reg;
            wr.key_en      = 1'b1;
            wr.val_en      = 1'b1;
            wr.meta_en     = 1'b1;
            wr.key         = key_reg;
            wr.value       = value_reg;
            wr.meta.expiry = (func_reg == kvc_pkg::FUNC_SETTTL) ? exp_new_reg : '0;
            wr.meta.count  = kvc_pkg::COUNT_BITS'(1);
            wr.meta.stamp  = stamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_FIND;
            policy_reg    <= 1'b0;
            cap_reg       <= CW'(3);
            now_reg       <= '0;
            stamp_reg     <= '0;
            valid_reg     <= '0;
            hasexp_reg    <= '0;
            scan_addr_reg <= '0;
            data_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == kvc_pkg::REG_CAPACITY) begin
                    cap_reg <= pwdata[CW-1:0];
                end else begin
                    policy_reg <= pwdata[0];
                end
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        func_reg        <= s_func;
                        key_reg         <= s_key;
                        value_reg       <= s_value;
                        life_reg        <= s_lifetime_seconds;
                        res_status_reg  <= kvc_pkg::ST_OK;
                        res_rv_reg      <= '0;
                        res_ttl_reg     <= '0;
                        res_ev_reg      <= 1'b0;
                        res_cleared_reg <= '0;
                        state_reg       <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    exp_new_reg    <= exp_sum[32] ? '1 : exp_sum[31:0];
                    scan_addr_reg  <= '0;
                    data_vld_reg   <= 1'b0;
                    hit_reg        <= 1'b0;
                    live_cnt_reg   <= '0;
                    free_found_reg <= 1'b0;
                    vic_found_reg  <= 1'b0;
                    if (func_reg == kvc_pkg::FUNC_TICK) begin
                        if (now_reg != '1) begin
                            now_reg <= now_reg + kvc_pkg::TIME_BITS'(1);
                        end
                        state_reg <= S_DONE;
                    end else if (func_reg == kvc_pkg::FUNC_CLEAR) begin
                        mode_reg  <= M_CLEAR;
                        state_reg <= S_SCAN;
                    end else if (func_reg > kvc_pkg::FUNC_TICK) begin
                        state_reg <= S_DONE;
                    end else if ((func_reg == kvc_pkg::FUNC_SETTTL ||
                                  func_reg == kvc_pkg::FUNC_EXPIRE) && life_reg == '0) begin
                        res_status_reg <= kvc_pkg::ST_BADLIFE;
                        state_reg      <= S_DONE;
                    end else begin
                        mode_reg  <= M_FIND;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_addr_reg < SW'(N)) begin
                        scan_addr_reg <= scan_addr_reg + SW'(1);
                        data_vld_reg  <= 1'b1;
                        data_idx_reg  <= scan_addr_reg[IW-1:0];
                    end else begin
                        data_vld_reg <= 1'b0;
                    end
                    if (data_vld_reg) begin
                        if (mode_reg == M_FIND && e_match) begin
                            if (e_live) begin
                                hit_reg      <= 1'b1;
                                hit_idx_reg  <= data_idx_reg;
                                hit_meta_reg <= rd_meta;
                                hit_val_reg  <= rd_value;
                            end else begin
                                valid_reg[data_idx_reg]  <= 1'b0;
                                hasexp_reg[data_idx_reg] <= 1'b0;
                            end
                        end
                        if (e_live) begin
                            live_cnt_reg <= live_cnt_reg + CW'(1);
                            if (e_better) begin
                                vic_found_reg <= 1'b1;
                                vic_idx_reg   <= data_idx_reg;
                                vic_count_reg <= rd_meta.count;
                                vic_stamp_reg <= rd_meta.stamp;
                            end
                        end else if (!free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= data_idx_reg;
                        end
                    end
                    if (scan_last) begin
                        case (mode_reg)
                            M_CLEAR: begin
                                res_cleared_reg <= live_cnt_reg + CW'(e_live);
                                valid_reg       <= '0;
                                hasexp_reg      <= '0;
                                state_reg       <= S_DONE;
                            end
                            M_VICTIM: state_reg <= S_EVICT;
                            default:  state_reg <= S_ACT;
                        endcase
                    end
                end
                S_ACT: begin
                    if (hit_reg) begin
                        state_reg <= S_DONE;
                        case (func_reg)
                            kvc_pkg::FUNC_SET: begin
                                hasexp_reg[hit_idx_reg] <= 1'b0;
                                stamp_reg <= stamp_reg + kvc_pkg::STAMP_BITS'(1);
                            end
                            kvc_pkg::FUNC_SETTTL, kvc_pkg::FUNC_EXPIRE: begin
                                hasexp_reg[hit_idx_reg] <= 1'b1;
                                stamp_reg <= stamp_reg + kvc_pkg::STAMP_BITS'(1);
                            end
                            kvc_pkg::FUNC_GET: begin
                                res_rv_reg <= hit_val_reg;
                                stamp_reg  <= stamp_reg + kvc_pkg::STAMP_BITS'(1);
                            end
                            kvc_pkg::FUNC_DEL: begin
                                valid_reg[hit_idx_reg]  <= 1'b0;
                                hasexp_reg[hit_idx_reg] <= 1'b0;
                            end
                            kvc_pkg::FUNC_TTL: begin
                                if (hasexp_reg[hit_idx_reg]) begin
                                    res_ttl_reg <= $signed({1'b0,
                                        hit_meta_reg.expiry - now_reg});
                                end else begin
                                    res_ttl_reg <= kvc_pkg::TTL_NONE;
                                end
                            end
                            default: ;
                        endcase
                    end else if (is_set) begin
                        state_reg <= S_EVICT;
                    end else begin
                        state_reg      <= S_DONE;
                        res_status_reg <= kvc_pkg::ST_MISS;
                        if (func_reg == kvc_pkg::FUNC_TTL) begin
                            res_ttl_reg <= kvc_pkg::TTL_ABSENT;
                        end
                    end
                end
                S_EVICT: begin
                    if (live_cnt_reg >= cap_eff) begin
                        valid_reg[vic_idx_reg]  <= 1'b0;
                        hasexp_reg[vic_idx_reg] <= 1'b0;
                        res_ev_reg <= 1'b1;
                        if (live_cnt_reg - CW'(1) >= cap_eff) begin
                            mode_reg       <= M_VICTIM;
                            scan_addr_reg  <= '0;
                            data_vld_reg   <= 1'b0;
                            live_cnt_reg   <= '0;
                            free_found_reg <= 1'b0;
                            vic_found_reg  <= 1'b0;
                            state_reg      <= S_SCAN;
                        end else begin
                            live_cnt_reg <= live_cnt_reg - CW'(1);
                            if (!free_found_reg || vic_idx_reg < free_idx_reg) begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= vic_idx_reg;
                            end
                            state_reg <= S_INSERT;
                        end
                    end else begin
                        state_reg <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    valid_reg[free_idx_reg]  <= 1'b1;
                    hasexp_reg[free_idx_reg] <= (func_reg == kvc_pkg::FUNC_SETTTL);
                    stamp_reg <= stamp_reg + kvc_pkg::STAMP_BITS'(1);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= res_status_reg;
                        m_rv_reg      <= res_rv_reg;
                        m_ttl_reg     <= res_ttl_reg;
                        m_ev_reg      <= res_ev_reg;
                        m_cleared_reg <= res_cleared_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_value    = m_rv_reg;
    assign m_ttl_remaining = m_ttl_reg;
    assign m_evicted       = m_ev_reg;
    assign m_cleared_count = m_cleared_reg;

    a_insert_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INSERT |-> free_found_reg)
        else $error("insert without a free slot");

    a_evict_has_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVICT && live_cnt_reg >= cap_eff) |-> vic_found_reg)
        else $error("eviction without a victim");

    a_hit_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACT && hit_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on an invalid entry");

    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INSERT |=> valid_reg[$past(free_idx_reg)])
        else $error("inserted entry not marked valid");

endmodule
`default_nettype wire
